// File: rtl/llrr_pkg.sv
package llrr_pkg;

	// Width of every index field on the ports
	localparam int FIELD_W = 11;
	// Width of a stored link: holds up to 2047 + 1
	localparam int VAL_W   = 12;

	// Command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic rd;          // read both tables at the request indexes
		logic sweep_init;  // load the sweep counter with the first entry
		logic sweep_wr;    // link the entry under the sweep counter, advance
		logic splice;      // write both splice links, load the result
	} llrr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sweep_done;  // sweep counter has passed the list length
	} llrr_stat_t;

endpackage

// File: rtl/llrr_if.sv
interface llrr_req_if;
	import llrr_pkg::*;
	logic               valid;
	logic               ready;
	logic [0:0]         cmd;
	logic [FIELD_W-1:0] low_index;
	logic [FIELD_W-1:0] high_index;

	modport source (output valid, output cmd, output low_index, output high_index,
		input ready);
	modport sink (input valid, input cmd, input low_index, input high_index,
		output ready);
endinterface

interface llrr_rsp_if;
	import llrr_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] left_neighbor;
	logic [FIELD_W-1:0] right_neighbor;

	modport source (output valid, output left_neighbor, output right_neighbor,
		input ready);
	modport sink (input valid, input left_neighbor, input right_neighbor,
		output ready);
endinterface

// File: rtl/llrr_ctrl.sv
module llrr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [0:0]            in_cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output llrr_pkg::llrr_cmd_t   cmd,
	input  llrr_pkg::llrr_stat_t  stat
);
	import llrr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_SPLICE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands for the datapath
	always_comb begin
		cmd            = '0;
		cmd.rd         = accept && (in_cmd == CMD_REMOVE);
		cmd.sweep_init = accept && (in_cmd == CMD_START);
		cmd.sweep_wr   = (state_q == ST_SWEEP) && !stat.sweep_done;
		cmd.splice     = (state_q == ST_SPLICE) && out_free;
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.splice) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_cmd == CMD_REMOVE) ? ST_SPLICE : ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (stat.sweep_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SPLICE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/llrr_dpath.sv
module llrr_dpath #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [llrr_pkg::FIELD_W-1:0]  cfg_wdata,
	input  logic [llrr_pkg::FIELD_W-1:0]  low_index,
	input  logic [llrr_pkg::FIELD_W-1:0]  high_index,
	output logic [llrr_pkg::FIELD_W-1:0]  left_neighbor,
	output logic [llrr_pkg::FIELD_W-1:0]  right_neighbor,
	input  llrr_pkg::llrr_cmd_t           cmd,
	output llrr_pkg::llrr_stat_t          stat
);
	import llrr_pkg::*;

	localparam int DEPTH = MAX_ENTRIES + 2;
	localparam int AW    = $clog2(DEPTH);

	logic [VAL_W-1:0]   prev_mem [DEPTH];
	logic [VAL_W-1:0]   next_mem [DEPTH];

	logic [FIELD_W-1:0] num_entries_q;
	logic [FIELD_W-1:0] eff_len;
	logic [VAL_W-1:0]   cnt_q;
	logic [VAL_W-1:0]   prev_rd_q;
	logic [VAL_W-1:0]   next_rd_q;
	logic               lo_ok_q;
	logic               hi_ok_q;
	logic [VAL_W-1:0]   left;
	logic [VAL_W-1:0]   right;
	logic               left_ok;
	logic               right_ok;
	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] right_q;

	// Hold the list length; eff_len saturates it to MAX_ENTRIES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= FIELD_W'(MAX_ENTRIES);
		end else if (cfg_we) begin
			num_entries_q <= cfg_wdata;
		end
	end

	assign eff_len = (32'(num_entries_q) > MAX_ENTRIES) ? FIELD_W'(MAX_ENTRIES)
		: num_entries_q;

	// Sweep counter over entries 1..n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep_init) begin
			cnt_q <= VAL_W'(1);
		end else if (cmd.sweep_wr) begin
			cnt_q <= cnt_q + VAL_W'(1);
		end
	end

	assign stat.sweep_done = cnt_q > {1'b0, eff_len};

	// Read the predecessor of low and the successor of high
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			prev_rd_q <= prev_mem[AW'(low_index)];
			next_rd_q <= next_mem[AW'(high_index)];
			lo_ok_q   <= 32'(low_index) < DEPTH;
			hi_ok_q   <= 32'(high_index) < DEPTH;
		end
	end

	// Indexes beyond the table read as zero
	assign left     = lo_ok_q ? prev_rd_q : '0;
	assign right    = hi_ok_q ? next_rd_q : '0;
	assign left_ok  = 32'(left) < DEPTH;
	assign right_ok = 32'(right) < DEPTH;

	// Write links: sweep relinks in order, splice joins left to right
	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			prev_mem[AW'(cnt_q)] <= cnt_q - VAL_W'(1);
		end else if (cmd.splice && right_ok) begin
			prev_mem[AW'(right)] <= left;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			next_mem[AW'(cnt_q)] <= cnt_q + VAL_W'(1);
		end else if (cmd.splice && left_ok) begin
			next_mem[AW'(left)] <= right;
		end
	end

	// Load the result; a successor past the list end reports none
	always_ff @(posedge clk) begin
		if (cmd.splice) begin
			left_q  <= left[FIELD_W-1:0];
			right_q <= (right <= {1'b0, eff_len}) ? right[FIELD_W-1:0] : '0;
		end
	end

	assign left_neighbor  = left_q;
	assign right_neighbor = right_q;

endmodule

// File: rtl/linked_list_range_remover.sv
// Channel   Dir  Fields                              Handshake
// request   in   cmd, low_index, high_index          valid/ready
// result    out  left_neighbor, right_neighbor       valid/ready
// cfg       in   cfg_wdata (num_entries)             cfg_we, no wait
//
// Remove reads both link tables, then writes the splice and loads the result
// register. Start sweeps the list length, saturated to MAX_ENTRIES; the sweep
// writes one entry per cycle per table. Reset clears control and loads the
// length register with MAX_ENTRIES; the tables hold nothing valid until a
// start. A result waiting in the output register does not block a new item;
// only the splice cycle of the following remove waits for it to empty.
module linked_list_range_remover #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [llrr_pkg::FIELD_W-1:0]  cfg_wdata,
	llrr_req_if.sink                      request,
	llrr_rsp_if.source                    result
);
	import llrr_pkg::*;

	llrr_cmd_t  cmd;
	llrr_stat_t stat;

	llrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.in_cmd    (request.cmd),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	llrr_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.low_index      (request.low_index),
		.high_index     (request.high_index),
		.left_neighbor  (result.left_neighbor),
		.right_neighbor (result.right_neighbor),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import llrr_pkg::*;

	localparam int MAX_ENTRIES = 1024;
	localparam int DEPTH       = MAX_ENTRIES + 2;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_DIRECTED  = 28;
	localparam int N_PHASES    = 12;

	typedef struct packed {
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] right;
	} neighbors_t;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
	} list_op_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_START, ROW_REMOVE} row_kind_t;

	// a: list length for ROW_CFG, low index otherwise; b: high index
	typedef struct packed {
		row_kind_t          kind;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic               typed;
		logic [FIELD_W-1:0] exp_left;
		logic [FIELD_W-1:0] exp_right;
	} directed_row_t;

	typedef struct packed {
		logic [FIELD_W-1:0] length;
		logic [9:0]         items;
		logic [6:0]         send_pct;
		logic [6:0]         recv_pct;
	} phase_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [FIELD_W-1:0] cfg_wdata;

	llrr_req_if req_ch ();
	llrr_rsp_if rsp_ch ();

	linked_list_range_remover #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.request  (req_ch),
		.result   (rsp_ch)
	);

	// Directed items: ends of the list, extreme lengths, dead, reversed and
	// out-of-table ranges, zero and saturated lengths
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_CFG,    11'd1024, 11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_START,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1,    11'd1,    1'b1, 11'd0,    11'd2},
		'{ROW_REMOVE, 11'd1024, 11'd1024, 1'b1, 11'd1023, 11'd0},
		'{ROW_REMOVE, 11'd2,    11'd1023, 1'b1, 11'd0,    11'd0},
		'{ROW_START,  11'd2047, 11'd2047, 1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd512,  11'd512,  1'b1, 11'd511,  11'd513},
		'{ROW_REMOVE, 11'd512,  11'd512,  1'b1, 11'd511,  11'd513},
		'{ROW_REMOVE, 11'd600,  11'd500,  1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd2047, 11'd2047, 1'b1, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1026, 11'd1024, 1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1,    11'd1024, 1'b0, 11'd0,    11'd0},
		'{ROW_CFG,    11'd2047, 11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_START,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1024, 11'd1024, 1'b1, 11'd1023, 11'd0},
		'{ROW_REMOVE, 11'd1,    11'd1,    1'b1, 11'd0,    11'd2},
		'{ROW_CFG,    11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_START,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1,    11'd1,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1024, 11'd1024, 1'b0, 11'd0,    11'd0},
		'{ROW_CFG,    11'd1,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_START,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd1,    11'd1,    1'b1, 11'd0,    11'd0},
		'{ROW_CFG,    11'd3,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_START,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd2,    11'd2,    1'b1, 11'd1,    11'd3},
		'{ROW_REMOVE, 11'd1,    11'd3,    1'b1, 11'd0,    11'd0},
		'{ROW_REMOVE, 11'd0,    11'd0,    1'b0, 11'd0,    11'd0}
	};

	// Random phases: length setting, item count, sender and receiver idle rates
	phase_t phases [N_PHASES] = '{
		'{11'd5,    10'd150, 7'd7,  7'd61},
		'{11'd1024, 10'd200, 7'd7,  7'd61},
		'{11'd1,    10'd60,  7'd7,  7'd61},
		'{11'd37,   10'd150, 7'd7,  7'd61},
		'{11'd0,    10'd40,  7'd61, 7'd7},
		'{11'd2047, 10'd150, 7'd61, 7'd7},
		'{11'd12,   10'd150, 7'd61, 7'd7},
		'{11'd300,  10'd150, 7'd61, 7'd7},
		'{11'd2,    10'd80,  7'd0,  7'd0},
		'{11'd64,   10'd200, 7'd0,  7'd0},
		'{11'd1000, 10'd150, 7'd0,  7'd0},
		'{11'd3,    10'd190, 7'd0,  7'd0}
	};

	// Shadow of the link tables and the length register
	int unsigned        prev_links [DEPTH];
	int unsigned        next_links [DEPTH];
	bit                 prev_known [DEPTH];
	bit                 next_known [DEPTH];
	logic [FIELD_W-1:0] length_reg = FIELD_W'(MAX_ENTRIES);

	neighbors_t pending_neighbors [$];

	// Stimulus bookkeeping: which entries a well-formed remove may still name
	bit          alive [1:MAX_ENTRIES];
	int          live_count;
	int          doomed [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned removes_sent;
	int unsigned starts_sent;
	int unsigned results_checked;
	int unsigned settings_written;

	function automatic int active_len();
		return (length_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(length_reg);
	endfunction

	// Link every entry of the list to its neighbors
	function automatic void relink_all();
		int n;
		n = active_len();
		for (int i = 1; i <= n; i++) begin
			prev_links[i] = i - 1;
			next_links[i] = i + 1;
			prev_known[i] = 1'b1;
			next_known[i] = 1'b1;
		end
	endfunction

	// Join the predecessor of lo to the successor of hi, return both
	function automatic neighbors_t splice_range(logic [FIELD_W-1:0] lo,
			logic [FIELD_W-1:0] hi);
		int unsigned left;
		int unsigned right;
		neighbors_t  nb;
		left  = (lo < DEPTH) ? prev_links[lo] : 0;
		right = (hi < DEPTH) ? next_links[hi] : 0;
		if (left < DEPTH) begin
			next_links[left] = right;
			next_known[left] = 1'b1;
		end
		if (right < DEPTH) begin
			prev_links[right] = left;
			prev_known[right] = 1'b1;
		end
		nb.left  = left[FIELD_W-1:0];
		nb.right = (right <= active_len()) ? right[FIELD_W-1:0] : '0;
		return nb;
	endfunction

	function automatic bit reads_defined(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
		return (lo >= DEPTH || prev_known[lo]) && (hi >= DEPTH || next_known[hi]);
	endfunction

	function automatic void mark_all_live();
		int n;
		n = active_len();
		for (int i = 1; i <= MAX_ENTRIES; i++)
			alive[i] = (i <= n);
		live_count = n;
	endfunction

	function automatic void clear_live();
		for (int i = 1; i <= MAX_ENTRIES; i++)
			alive[i] = 1'b0;
		live_count = 0;
	endfunction

	// Choose the next random item: mostly removes of live ranges, some noise and starts
	task automatic pick_random_op(output list_op_t op);
		int n;
		int span;
		int cur;
		int nx;
		int steps;
		int s;
		int tries;
		n = active_len();
		span = (n == 0) ? 1 : n;
		doomed.delete();
		op.cmd = CMD_REMOVE;
		op.lo  = FIELD_W'($urandom);
		op.hi  = FIELD_W'($urandom);
		if ($urandom_range(99) < 2 || (live_count == 0 && n != 0)) begin
			op.cmd = CMD_START;
			return;
		end
		// noise: dead, reversed and out-of-table ranges
		if (n == 0 || $urandom_range(99) < 12) begin
			for (tries = 0; tries < 64; tries++) begin
				case ($urandom_range(3))
					0: begin
						op.lo = FIELD_W'($urandom_range(1, span));
						op.hi = FIELD_W'($urandom_range(1, span));
					end
					1: begin
						op.lo = FIELD_W'($urandom_range(2047));
						op.hi = FIELD_W'($urandom_range(2047));
					end
					2: begin
						op.lo = FIELD_W'($urandom_range(DEPTH, 2047));
						op.hi = FIELD_W'($urandom_range(1, span));
					end
					default: begin
						op.lo = FIELD_W'($urandom_range(1, span));
						op.hi = FIELD_W'($urandom_range(DEPTH, 2047));
					end
				endcase
				if (reads_defined(op.lo, op.hi))
					return;
			end
			op.cmd = CMD_START;
			return;
		end
		// well-formed: a live low entry, then walk forward over live entries
		cur = $urandom_range(1, n);
		while (!alive[cur])
			cur = (cur % n) + 1;
		op.lo = FIELD_W'(cur);
		doomed.insert(doomed.size(), cur);
		s = $urandom_range(99);
		if (s < 70)
			steps = $urandom_range(3);
		else if (s < 95)
			steps = $urandom_range(n / 4);
		else
			steps = n;
		for (s = 0; s < steps; s++) begin
			nx = next_links[cur];
			if (nx == 0 || nx > n || !alive[nx])
				break;
			cur = nx;
			doomed.insert(doomed.size(), cur);
		end
		op.hi = FIELD_W'(cur);
		if (!reads_defined(op.lo, op.hi)) begin
			op.cmd = CMD_START;
			doomed.delete();
		end
	endtask

	// Drive one item, hold it until accepted, then predict its result
	task automatic send_op(input list_op_t op, input logic typed, input neighbors_t typed_nb);
		neighbors_t nb;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= op.cmd;
		req_ch.low_index  <= op.lo;
		req_ch.high_index <= op.hi;
		do @(posedge clk); while (!req_ch.ready);
		if (op.cmd == CMD_START) begin
			relink_all();
			starts_sent++;
		end else begin
			nb = splice_range(op.lo, op.hi);
			pending_neighbors.insert(pending_neighbors.size(), typed ? typed_nb : nb);
			removes_sent++;
		end
	endtask

	// Stop sending until every expected result is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_neighbors.size() != 0);
	endtask

	// Write the length while idle: drain the results and wait out any start sweep still running
	task automatic write_length(input logic [FIELD_W-1:0] value);
		drain_results();
		repeat (active_len() + 16) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		length_reg = value;
		settings_written++;
		clear_live();
	endtask

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Stall the receiver and compare each result with the oldest expectation
	always @(posedge clk) begin
		neighbors_t want;
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (rsp_ch.valid && rsp_ch.ready) begin
			results_checked++;
			if (pending_neighbors.size() == 0) begin
				$error("result with no remove pending: left_neighbor %0d right_neighbor %0d",
					rsp_ch.left_neighbor, rsp_ch.right_neighbor);
				error_count++;
			end else begin
				want = pending_neighbors.pop_front();
				if (rsp_ch.left_neighbor !== want.left) begin
					$error("left_neighbor: expected %0d, actual %0d",
						want.left, rsp_ch.left_neighbor);
					error_count++;
				end
				if (rsp_ch.right_neighbor !== want.right) begin
					$error("right_neighbor: expected %0d, actual %0d",
						want.right, rsp_ch.right_neighbor);
					error_count++;
				end
			end
		end
	end

	initial begin
		list_op_t op;
		int       k;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_START;
		req_ch.low_index  <= '0;
		req_ch.high_index <= '0;
		send_idle_pct = 32'(phases[0].send_pct);
		recv_idle_pct = 32'(phases[0].recv_pct);
		clear_live();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			op.cmd = (directed_rows[i].kind == ROW_REMOVE) ? CMD_REMOVE : CMD_START;
			op.lo  = directed_rows[i].a;
			op.hi  = directed_rows[i].b;
			case (directed_rows[i].kind)
				ROW_CFG: begin
					write_length(directed_rows[i].a);
				end
				default: begin
					send_op(op, directed_rows[i].typed,
						{directed_rows[i].exp_left, directed_rows[i].exp_right});
				end
			endcase
		end

		// Random phases
		for (int p = 0; p < N_PHASES; p++) begin
			send_idle_pct = 32'(phases[p].send_pct);
			recv_idle_pct = 32'(phases[p].recv_pct);
			write_length(phases[p].length);
			for (k = 0; k < phases[p].items; k++) begin
				if (k == phases[p].items / 2 || $urandom_range(99) == 0)
					drain_results();
				pick_random_op(op);
				send_op(op, 1'b0, '0);
				if (op.cmd == CMD_START) begin
					mark_all_live();
				end else begin
					foreach (doomed[d]) begin
						if (alive[doomed[d]]) begin
							alive[doomed[d]] = 1'b0;
							live_count--;
						end
					end
				end
			end
		end

		// Wait out the last results and any sweep still running
		drain_results();
		repeat (active_len() + 16) @(posedge clk);

		$display("Covered %0d removes and %0d starts over %0d length settings,",
			removes_sent, starts_sent, settings_written);
		$display("with %0d results compared and %0d mismatches.",
			results_checked, error_count);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
